// ===== rtl/vn_pkg.sv =====
`timescale 1ns / 1ps

package vn_pkg;

  localparam int QUO_BITS  = 33;
  localparam int ROOT_BITS = 17;
  localparam int RAD_BITS  = 2 * ROOT_BITS;
  localparam int REM_BITS  = ROOT_BITS + 2;
  localparam int UNIT_BITS = 16;

  localparam logic [UNIT_BITS-1:0] UNIT_MAX = {1'b0, {(UNIT_BITS-1){1'b1}}};

  typedef struct packed {
    logic       valid;
    logic       zero;
    logic [2:0] neg;
  } side_t;

endpackage

// ===== rtl/vn_div.sv =====
`timescale 1ns / 1ps

module vn_div #(
  parameter int W = 32
) (
  input  logic                       clk,
  input  logic [W-1:0]               num,
  input  logic [W-1:0]               den,
  output logic [vn_pkg::QUO_BITS-1:0] quo
);
  import vn_pkg::*;

  logic [W-1:0]        rem_r [QUO_BITS-1];
  logic [W-1:0]        den_r [QUO_BITS-1];
  logic [QUO_BITS-1:0] quo_r [QUO_BITS];

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
    logic [W:0]          part;
    logic [W-1:0]        den_in;
    logic [QUO_BITS-1:0] quo_in;
    logic                take;

    if (k == 0) begin : g_first
      assign part   = {1'b0, num};
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign part   = {rem_r[k-1], 1'b0};
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign take = part >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      quo_r[k] <= {quo_in[QUO_BITS-2:0], take};
    end

    if (k < QUO_BITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[k] <= take ? W'(part - {1'b0, den_in}) : part[W-1:0];
        den_r[k] <= den_in;
      end
    end
  end

  assign quo = quo_r[QUO_BITS-1];

endmodule

// ===== rtl/vn_sqrt.sv =====
`timescale 1ns / 1ps

module vn_sqrt (
  input  logic                        clk,
  input  logic [vn_pkg::QUO_BITS-1:0]  rad,
  output logic [vn_pkg::ROOT_BITS-1:0] root
);
  import vn_pkg::*;

  logic [RAD_BITS-1:0]  x_r    [ROOT_BITS-1];
  logic [REM_BITS-1:0]  rem_r  [ROOT_BITS-1];
  logic [ROOT_BITS-1:0] root_r [ROOT_BITS];

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
    logic [RAD_BITS-1:0]  x_in;
    logic [REM_BITS-1:0]  rem_in;
    logic [ROOT_BITS-1:0] root_in;
    logic [REM_BITS+1:0]  cur;
    logic [REM_BITS+1:0]  trial;
    logic                 take;

    if (k == 0) begin : g_first
      assign x_in    = {{(RAD_BITS-QUO_BITS){1'b0}}, rad};
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign x_in    = x_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    assign cur   = {rem_in, x_in[RAD_BITS-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign take  = cur >= trial;

    always_ff @(posedge clk) begin
      root_r[k] <= {root_in[ROOT_BITS-2:0], take};
    end

    if (k < ROOT_BITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[k] <= take ? REM_BITS'(cur - trial) : cur[REM_BITS-1:0];
        x_r[k]   <= {x_in[RAD_BITS-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[ROOT_BITS-1];

endmodule

// ===== rtl/vector3_normalize_core.sv =====
`timescale 1ns / 1ps

// Scales a signed vector (comp_x, comp_y, comp_z) to unit length and returns
// the components in signed Q1.15, rounded to nearest with halves away from
// zero; +1.0 saturates to 32767, -1.0 stays -32768. An all-zero vector gives
// zero components with zero_vector_error set. busy is always low: one item
// may be started every cycle, and its result appears with done. Each lane
// holds a bit-per-stage divider (33 stages) and square-root unit (17
// stages), plus magnitude, square, sum and output stages. Results cannot
// be held off.
module vector3_normalize_core #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COMPONENT_BITS-1:0]    comp_x,
  input  logic signed [COMPONENT_BITS-1:0]    comp_y,
  input  logic signed [COMPONENT_BITS-1:0]    comp_z,
  output logic                                done,
  output logic signed [vn_pkg::UNIT_BITS-1:0] unit_x,
  output logic signed [vn_pkg::UNIT_BITS-1:0] unit_y,
  output logic signed [vn_pkg::UNIT_BITS-1:0] unit_z,
  output logic                                zero_vector_error
);
  import vn_pkg::*;

  localparam int N       = COMPONENT_BITS;
  localparam int SQ_BITS = 2 * N;
  localparam int DLY     = QUO_BITS + ROOT_BITS;
  localparam int LATENCY = 3 + DLY + 1;

  logic [N-1:0]         comp_in [3];
  logic [N-1:0]         mag_r   [3];
  logic [SQ_BITS-1:0]   sq_r    [3];
  logic [SQ_BITS-1:0]   num_r   [3];
  logic [SQ_BITS-1:0]   sum_r;
  logic [ROOT_BITS-1:0] root_w  [3];
  logic [UNIT_BITS-1:0] unit_w  [3];
  logic [UNIT_BITS-1:0] unit_r  [3];
  side_t                side1, side2, side3;
  side_t                side_dly [DLY];
  side_t                side_end;

  assign busy = 1'b0;

  assign comp_in[0] = comp_x;
  assign comp_in[1] = comp_y;
  assign comp_in[2] = comp_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      side1 <= '0;
      side2 <= '0;
      side3 <= '0;
    end else begin
      side1.valid <= start && !busy;
      side1.zero  <= (comp_x == '0) && (comp_y == '0) && (comp_z == '0);
      side1.neg   <= {comp_z[N-1], comp_y[N-1], comp_x[N-1]};
      side2       <= side1;
      side3       <= side2;
    end
  end

  for (genvar j = 0; j < DLY; j++) begin : g_dly
    always_ff @(posedge clk) begin
      if (rst) begin
        side_dly[j] <= '0;
      end else if (j == 0) begin
        side_dly[j] <= side3;
      end else begin
        side_dly[j] <= side_dly[(j == 0) ? 0 : j-1];
      end
    end
  end

  assign side_end = side_dly[DLY-1];

  always_ff @(posedge clk) begin
    sum_r <= SQ_BITS'(sq_r[0] + sq_r[1] + sq_r[2]);
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic [UNIT_BITS:0]   half_up;
    logic [UNIT_BITS-1:0] q;
    logic [QUO_BITS-1:0]  quo_w;

    always_ff @(posedge clk) begin
      mag_r[i] <= comp_in[i][N-1] ? N'(~comp_in[i] + 1'b1) : comp_in[i];
      sq_r[i]  <= mag_r[i] * mag_r[i];
      num_r[i] <= sq_r[i];
    end

    vn_div #(.W(SQ_BITS)) u_div (
      .clk (clk),
      .num (num_r[i]),
      .den (sum_r),
      .quo (quo_w)
    );

    vn_sqrt u_sqrt (
      .clk  (clk),
      .rad  (quo_w),
      .root (root_w[i])
    );

    assign half_up = root_w[i] + 1'b1;
    assign q       = half_up[UNIT_BITS:1];

    always_comb begin
      if (side_end.zero) begin
        unit_w[i] = '0;
      end else if (side_end.neg[i]) begin
        unit_w[i] = UNIT_BITS'(~q + 1'b1);
      end else if (q[UNIT_BITS-1]) begin
        unit_w[i] = UNIT_MAX;
      end else begin
        unit_w[i] = q;
      end
    end

    always_ff @(posedge clk) begin
      unit_r[i] <= unit_w[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side_end.valid;
    end
  end

  always_ff @(posedge clk) begin
    zero_vector_error <= side_end.zero;
  end

  assign unit_x = unit_r[0];
  assign unit_y = unit_r[1];
  assign unit_z = unit_r[2];

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LATENCY done)
    else $error("item result missing after pipeline latency");

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    done && zero_vector_error |-> unit_x == '0 && unit_y == '0 && unit_z == '0)
    else $error("zero vector gave nonzero components");

  a_unit_len: assert property (@(posedge clk) disable iff (rst)
    done |-> !(unit_x == 16'sh8000 && unit_y == 16'sh8000))
    else $error("two components at minus one");
`endif

endmodule
